/* rtl/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg
// types, codes and calendar helpers shared by the clock/calendar core
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int unsigned MS_PER_SEC = 1000;
    localparam int unsigned YEAR_MAX   = 9999;
    localparam int unsigned RESET_YEAR = 2000;
    localparam int unsigned RESET_DOW  = 6;
    localparam int unsigned RECIP_25   = 5243;   // ceil(2^17 / 25)
    localparam int unsigned RECIP_7    = 18725;  // ceil(2^17 / 7)

    typedef enum logic [3:0] {
        KIND_TICK      = 4'd0,
        KIND_INC_SEC   = 4'd1,
        KIND_INC_MIN   = 4'd2,
        KIND_INC_HOUR  = 4'd3,
        KIND_INC_DAY   = 4'd4,
        KIND_INC_MONTH = 4'd5,
        KIND_INC_YEAR  = 4'd6,
        KIND_DEC_SEC   = 4'd7,
        KIND_DEC_MIN   = 4'd8,
        KIND_DEC_HOUR  = 4'd9,
        KIND_DEC_DAY   = 4'd10,
        KIND_DEC_MONTH = 4'd11,
        KIND_DEC_YEAR  = 4'd12,
        KIND_ALIGN_UP  = 4'd13,
        KIND_ALIGN_DN  = 4'd14,
        KIND_CLAMP_DAY = 4'd15
    } t_kind;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] tick_ms;
    } t_in_word;

    typedef struct packed {
        logic [9:0]  millis;
        logic [5:0]  sec;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  day_of_month;
        logic [3:0]  month_num;
        logic [13:0] year_num;
        logic [2:0]  weekday;
        logic        leap_flag;
        logic [5:0]  changed_mask;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WK1,
        ST_WK2,
        ST_WK3,
        ST_WK4,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic adjust;
        logic wk1;
        logic wk2;
        logic wk3;
        logic wk4;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic acc_ge;
    } t_stat;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(23 * m / 9)
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/ccc_ctrl.sv */
// ----------------------------------------------------------------------------
// ccc_ctrl
// sequencer: accept, second stepping or field adjust, weekday pipeline, output handoff
// ----------------------------------------------------------------------------
module ccc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ccc_pkg::t_stat i_stat,
    output ccc_pkg::t_cmd  o_cmd
);
    import ccc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.is_tick) begin
                    o_cmd.adjust = 1'b1;
                    n_state      = ST_WK1;
                end else if (i_stat.acc_ge) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = ST_WK1;
                end
            end
            ST_WK1: begin
                o_cmd.wk1 = 1'b1;
                n_state   = ST_WK2;
            end
            ST_WK2: begin
                o_cmd.wk2 = 1'b1;
                n_state   = ST_WK3;
            end
            ST_WK3: begin
                o_cmd.wk3 = 1'b1;
                n_state   = ST_WK4;
            end
            ST_WK4: begin
                o_cmd.wk4 = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid && r_state == ST_IDLE)
        else $error("output load did not raise valid");

    a_wk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wk1 |=> o_cmd.wk2 ##1 o_cmd.wk3 ##1 o_cmd.wk4)
        else $error("weekday pipeline sequence broken");

endmodule

/* rtl/ccc_dpath.sv */
// ----------------------------------------------------------------------------
// ccc_dpath
// time and date registers, carry step, adjust logic, weekday and leap units
// ----------------------------------------------------------------------------
module ccc_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccc_pkg::t_in_word  i_in_word,
    input  ccc_pkg::t_cmd      i_cmd,
    output ccc_pkg::t_stat     o_stat,
    output ccc_pkg::t_out_word o_out_word
);
    import ccc_pkg::*;

    t_kind       r_kind;
    logic [16:0] r_acc;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic        r_leap;
    logic [2:0]  r_dow;
    logic [5:0]  r_mask;

    logic [6:0]  r_q100;
    logic [4:0]  r_q400;
    logic [6:0]  r_lq100;
    logic [4:0]  r_lq400;
    logic [13:0] r_s;
    logic [10:0] r_q7;

    t_out_word   r_out;

    // carry step
    logic [4:0]  len;
    logic [5:0]  s_src;
    logic        cy_min, cy_hour, cy_day, cy_mon, cy_year, yr_up;
    logic [5:0]  st_sec, st_min;
    logic [4:0]  st_hour, st_day, day_nx;
    logic [3:0]  st_month;
    logic [13:0] st_year;
    logic [5:0]  st_mask;

    always_comb begin
        len      = month_len(r_month, r_leap);
        s_src    = (r_kind == KIND_ALIGN_UP) ? 6'd59 : r_sec;
        cy_min   = (s_src == 6'd59);
        st_sec   = cy_min ? 6'd0 : s_src + 6'd1;
        cy_hour  = cy_min && (r_min == 6'd59);
        st_min   = cy_min ? ((r_min == 6'd59) ? 6'd0 : r_min + 6'd1) : r_min;
        cy_day   = cy_hour && (r_hour == 5'd23);
        st_hour  = cy_hour ? ((r_hour == 5'd23) ? 5'd0 : r_hour + 5'd1) : r_hour;
        day_nx   = ((r_day >= len) ? r_day - len : r_day) + 5'd1;
        cy_mon   = cy_day && (r_day == len);
        st_day   = cy_day ? day_nx : r_day;
        cy_year  = cy_mon && (r_month == 4'd12);
        st_month = cy_mon ? ((r_month == 4'd12) ? 4'd1 : r_month + 4'd1) : r_month;
        yr_up    = cy_year && (r_year < 14'(YEAR_MAX));
        st_year  = yr_up ? r_year + 14'd1 : r_year;
        st_mask  = {yr_up, cy_mon, cy_day, cy_hour, cy_min, 1'b1};
    end

    // field adjust, align and clamp
    logic [16:0] a_acc;
    logic [5:0]  a_sec, a_min;
    logic [4:0]  a_hour, a_day;
    logic [3:0]  a_month;
    logic [13:0] a_year;
    logic [5:0]  a_cmask, a_mask;

    always_comb begin
        a_acc   = r_acc;
        a_sec   = r_sec;
        a_min   = r_min;
        a_hour  = r_hour;
        a_day   = r_day;
        a_month = r_month;
        a_year  = r_year;
        a_cmask = '0;
        unique case (r_kind)
            KIND_TICK: begin
            end
            KIND_INC_SEC:   a_sec = (r_sec == 6'd59) ? 6'd0 : r_sec + 6'd1;
            KIND_INC_MIN:   a_min = (r_min == 6'd59) ? 6'd0 : r_min + 6'd1;
            KIND_INC_HOUR:  a_hour = (r_hour == 5'd23) ? 5'd0 : r_hour + 5'd1;
            KIND_INC_DAY:   a_day = day_nx;
            KIND_INC_MONTH: a_month = (r_month == 4'd12) ? 4'd1 : r_month + 4'd1;
            KIND_INC_YEAR: begin
                if (r_year < 14'(YEAR_MAX)) begin
                    a_year = r_year + 14'd1;
                end
            end
            KIND_DEC_SEC:   a_sec = (r_sec != 6'd0) ? r_sec - 6'd1 : 6'd59;
            KIND_DEC_MIN:   a_min = (r_min != 6'd0) ? r_min - 6'd1 : 6'd59;
            KIND_DEC_HOUR:  a_hour = (r_hour != 5'd0) ? r_hour - 5'd1 : 5'd23;
            KIND_DEC_DAY:   a_day = (r_day > 5'd1) ? r_day - 5'd1 : len;
            KIND_DEC_MONTH: a_month = (r_month > 4'd1) ? r_month - 4'd1 : 4'd12;
            KIND_DEC_YEAR: begin
                if (r_year > 14'd1) begin
                    a_year = r_year - 14'd1;
                end
            end
            KIND_ALIGN_UP: begin
                a_acc = '0;
                if (r_sec > 6'd30) begin
                    a_sec   = st_sec;
                    a_min   = st_min;
                    a_hour  = st_hour;
                    a_day   = st_day;
                    a_month = st_month;
                    a_year  = st_year;
                    a_cmask = st_mask;
                end else begin
                    a_sec = 6'd30;
                end
            end
            KIND_ALIGN_DN: begin
                a_acc = '0;
                a_sec = (r_sec < 6'd30) ? 6'd0 : 6'd30;
            end
            KIND_CLAMP_DAY: begin
                if (r_day > len) begin
                    a_day = len;
                end
            end
        endcase
        a_mask = a_cmask | {a_year != r_year, a_month != r_month, a_day != r_day,
                            a_hour != r_hour, a_min != r_min, a_sec != r_sec};
    end

    // weekday and leap arithmetic
    logic        early;
    logic [13:0] yy;
    logic [14:0] dd;
    logic [24:0] p_q100, p_lq100;
    logic [22:0] p_q400, p_lq400;
    logic [14:0] s_sum;
    logic        div4, div100, div400;
    logic [28:0] p_q7;
    logic [13:0] q7x7;
    logic [13:0] rem7;

    always_comb begin
        early   = (r_month < 4'd3);
        yy      = early ? r_year - 14'd1 : r_year;
        dd      = early ? 15'(r_day) + 15'(r_year) : 15'(r_day) + 15'(r_year) - 15'd2;
        p_q100  = 25'(yy[13:2]) * 25'(RECIP_25);
        p_q400  = 23'(yy[13:4]) * 23'(RECIP_25);
        p_lq100 = 25'(r_year[13:2]) * 25'(RECIP_25);
        p_lq400 = 23'(r_year[13:4]) * 23'(RECIP_25);
        s_sum   = 15'(month_term(r_month)) + dd + 15'd4 + 15'(yy[13:2])
                + 15'(r_q400) - 15'(r_q100);
        div4    = (r_year[1:0] == 2'd0);
        div100  = div4 && (r_year[13:2] == 12'(r_lq100) * 12'd25);
        div400  = (r_year[3:0] == 4'd0) && (r_year[13:4] == 10'(r_lq400) * 10'd25);
        p_q7    = 29'(r_s) * 29'(RECIP_7);
        q7x7    = {r_q7, 3'b000} - 14'(r_q7);
        rem7    = r_s - q7x7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_sec   <= '0;
            r_min   <= '0;
            r_hour  <= '0;
            r_day   <= 5'd1;
            r_month <= 4'd1;
            r_year  <= 14'(RESET_YEAR);
            r_leap  <= 1'b1;
            r_dow   <= 3'(RESET_DOW);
            r_mask  <= '0;
            r_kind  <= KIND_TICK;
        end else begin
            if (i_cmd.load) begin
                r_kind <= t_kind'(i_in_word.kind);
                r_mask <= '0;
                if (t_kind'(i_in_word.kind) == KIND_TICK) begin
                    r_acc <= r_acc + 17'(i_in_word.tick_ms);
                end
            end
            if (i_cmd.step) begin
                r_acc   <= r_acc - 17'(MS_PER_SEC);
                r_sec   <= st_sec;
                r_min   <= st_min;
                r_hour  <= st_hour;
                r_day   <= st_day;
                r_month <= st_month;
                r_year  <= st_year;
                r_mask  <= r_mask | st_mask;
            end
            if (i_cmd.adjust) begin
                r_acc   <= a_acc;
                r_sec   <= a_sec;
                r_min   <= a_min;
                r_hour  <= a_hour;
                r_day   <= a_day;
                r_month <= a_month;
                r_year  <= a_year;
                r_mask  <= a_mask;
            end
            if (i_cmd.wk2) begin
                r_leap <= div4 && (!div100 || div400);
            end
            if (i_cmd.wk4) begin
                r_dow <= rem7[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wk1) begin
            r_q100  <= p_q100[23:17];
            r_q400  <= p_q400[21:17];
            r_lq100 <= p_lq100[23:17];
            r_lq400 <= p_lq400[21:17];
        end
        if (i_cmd.wk2) begin
            r_s <= s_sum[13:0];
        end
        if (i_cmd.wk3) begin
            r_q7 <= p_q7[27:17];
        end
        if (i_cmd.load_out) begin
            r_out.millis       <= r_acc[9:0];
            r_out.sec          <= r_sec;
            r_out.minutes      <= r_min;
            r_out.hours        <= r_hour;
            r_out.day_of_month <= r_day;
            r_out.month_num    <= r_month;
            r_out.year_num     <= r_year;
            r_out.weekday      <= r_dow;
            r_out.leap_flag    <= r_leap;
            r_out.changed_mask <= r_mask;
        end
    end

    assign o_stat.is_tick = (r_kind == KIND_TICK);
    assign o_stat.acc_ge  = (r_acc >= 17'(MS_PER_SEC));
    assign o_out_word     = r_out;

    a_ms_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wk1 |-> r_acc < 17'(MS_PER_SEC))
        else $error("millisecond remainder not settled before weekday pass");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec < 6'd60 && r_min < 6'd60 && r_hour < 5'd24)
        else $error("time field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day != 5'd0 && r_month != 4'd0 && r_month < 4'd13
        && r_year != 14'd0 && r_year <= 14'(YEAR_MAX))
        else $error("date field out of range");

    a_step_marks_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_mask[0])
        else $error("second step did not mark the second field");

endmodule

/* rtl/calendar_clock_counter_core.sv */
// ----------------------------------------------------------------------------
// calendar_clock_counter_core
// real-time clock and calendar with tick, adjust, align and clamp words
// ----------------------------------------------------------------------------
// sequence: input accept, second stepping or field adjust, weekday passes wk1..wk4,
//   output handoff; a tick word carries 0..66 whole seconds, an adjust word none
// the second stepper does one second per cycle; a new word is taken only after the
// previous one is handed off, and it is taken while that result waits at the output
// reset: synchronous active low, clock set to 2000-01-01 00:00:00.000 saturday
// ----------------------------------------------------------------------------
module calendar_clock_counter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccc_pkg::t_out_word o_out_word
);
    import ccc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ccc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ccc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule
